// ===== rtl/ic3_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ic3_pkg: shared types and constants for the 3x3 image convolution stream
// Holds sizes, pixel and kernel types, the register map and the saturating
// output conversion used by the datapath.
// ----------------------------------------------------------------------------
package ic3_pkg;

	// Sizes.
	localparam int MAX_WIDTH      = 1024;
	localparam int COEF_FRAC_BITS = 14;
	localparam int PIX_W          = 8;
	localparam int NUM_CH         = 3;
	localparam int COEF_W         = 16;
	localparam int NUM_TAPS       = 3;
	localparam int ADDR_W         = $clog2(MAX_WIDTH);
	localparam int COL_W          = 11;
	localparam int ROW_W          = 13;
	localparam int KREG_W         = NUM_TAPS * COEF_W;
	localparam int CFG_IDX_W      = 3;
	localparam int PROD_W         = PIX_W + COEF_W;
	localparam int ROWSUM_W       = PROD_W + 2;
	localparam int SUM_W          = PROD_W + 4;
	localparam int FIFO_DEPTH     = 16;
	localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
	localparam int CNT_W          = FIFO_AW + 1;

	// Register reset values.
	localparam logic [COL_W-1:0]  WIDTH_RST  = COL_W'(1024);
	localparam logic [ROW_W-1:0]  HEIGHT_RST = ROW_W'(768);
	localparam logic [KREG_W-1:0] KTOP_RST   = 48'h0400_0800_0400;
	localparam logic [KREG_W-1:0] KMID_RST   = 48'h0800_1000_0800;
	localparam logic [KREG_W-1:0] KBOT_RST   = 48'h0400_0800_0400;

	// Register map.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = CFG_IDX_W'(0),
		REG_IMAGE_HEIGHT  = CFG_IDX_W'(1),
		REG_COLOR_MODE    = CFG_IDX_W'(2),
		REG_KERNEL_TOP    = CFG_IDX_W'(3),
		REG_KERNEL_MIDDLE = CFG_IDX_W'(4),
		REG_KERNEL_BOTTOM = CFG_IDX_W'(5)
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;
	// One pixel, channel 0 is red, 1 green, 2 blue.
	typedef pix_t [NUM_CH-1:0] px_t;
	// One window column, index 0 top row, 1 middle, 2 bottom.
	typedef px_t [NUM_TAPS-1:0] col_t;
	typedef logic [COEF_W-1:0] coef_t;
	// One kernel row, index 0 is the left coefficient.
	typedef coef_t [NUM_TAPS-1:0] krow_t;
	// Whole kernel, index 0 is the top row.
	typedef krow_t [NUM_TAPS-1:0] kern_t;

	// Line buffer entry: the two previous rows at one column.
	typedef struct packed {
		px_t upper;
		px_t middle;
	} line_t;

	// Per-item control carried along the pipeline.
	typedef struct packed {
		logic valid;
		logic e1;       // window ending at the current column
		logic e2;       // row-closing window with a zero right column
		logic last_row;
	} ctl_t;

	// One output beat.
	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
		logic last_of_run;
		logic end_of_frame;
	} res_t;

	// Drop the fraction bits and clamp the sum to the pixel range.
	function automatic pix_t sat_pix(input logic [SUM_W-1:0] v);
		logic [SUM_W-COEF_FRAC_BITS-1:0] sh;
		sh = v[SUM_W-1:COEF_FRAC_BITS];
		return (|sh[SUM_W-COEF_FRAC_BITS-1:PIX_W]) ? '1 : sh[PIX_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ic3_kernel_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ic3_kernel_mac: weighted sums of the 3x3 window
// Two pipeline stages: products, then row sums; the final add, truncation and
// saturation feed the result queue directly. Computes the regular window and
// the row-closing window (right column zero) side by side.
// ----------------------------------------------------------------------------
module ic3_kernel_mac
	import ic3_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire ctl_t   ctl_s1,
	input  wire col_t   prev2_s1,
	input  wire col_t   prev1_s1,
	input  wire col_t   cur_s1,
	input  wire kern_t  kern,
	input  wire logic   color_mode,
	output logic [1:0]  res_cnt,
	output res_t        res_a,
	output res_t        res_b
);

	ctl_t ctl_s2;
	ctl_t ctl_s3;

	// Products: a,c,e build the regular window; b,d the row-closing one.
	logic [PROD_W-1:0] pa_s2 [NUM_TAPS][NUM_CH];
	logic [PROD_W-1:0] pb_s2 [NUM_TAPS][NUM_CH];
	logic [PROD_W-1:0] pc_s2 [NUM_TAPS][NUM_CH];
	logic [PROD_W-1:0] pd_s2 [NUM_TAPS][NUM_CH];
	logic [PROD_W-1:0] pe_s2 [NUM_TAPS][NUM_CH];

	logic [ROWSUM_W-1:0] s1row_s3 [NUM_TAPS][NUM_CH];
	logic [ROWSUM_W-1:0] s2row_s3 [NUM_TAPS][NUM_CH];

	pix_t sat1 [NUM_CH];
	pix_t sat2 [NUM_CH];
	res_t r1;
	res_t r2;

	// Control pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// Multiply every pixel by its coefficient.
	always_ff @(posedge clk) begin
		for (int r = 0; r < NUM_TAPS; r++) begin
			for (int c = 0; c < NUM_CH; c++) begin
				pa_s2[r][c] <= PROD_W'(prev2_s1[r][c]) * PROD_W'(kern[r][0]);
				pb_s2[r][c] <= PROD_W'(prev1_s1[r][c]) * PROD_W'(kern[r][0]);
				pc_s2[r][c] <= PROD_W'(prev1_s1[r][c]) * PROD_W'(kern[r][1]);
				pd_s2[r][c] <= PROD_W'(cur_s1[r][c]) * PROD_W'(kern[r][1]);
				pe_s2[r][c] <= PROD_W'(cur_s1[r][c]) * PROD_W'(kern[r][2]);
			end
		end
	end

	// Sum each kernel row.
	always_ff @(posedge clk) begin
		for (int r = 0; r < NUM_TAPS; r++) begin
			for (int c = 0; c < NUM_CH; c++) begin
				s1row_s3[r][c] <= ROWSUM_W'(pa_s2[r][c]) + ROWSUM_W'(pc_s2[r][c])
					+ ROWSUM_W'(pe_s2[r][c]);
				s2row_s3[r][c] <= ROWSUM_W'(pb_s2[r][c]) + ROWSUM_W'(pd_s2[r][c]);
			end
		end
	end

	// Add the rows, truncate and saturate.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			sat1[c] = sat_pix(SUM_W'(s1row_s3[0][c]) + SUM_W'(s1row_s3[1][c])
				+ SUM_W'(s1row_s3[2][c]));
			sat2[c] = sat_pix(SUM_W'(s2row_s3[0][c]) + SUM_W'(s2row_s3[1][c])
				+ SUM_W'(s2row_s3[2][c]));
		end
	end

	// Assemble the beats; green and blue read zero in grey mode.
	always_comb begin
		r1.red          = sat1[0];
		r1.green        = color_mode ? sat1[1] : '0;
		r1.blue         = color_mode ? sat1[2] : '0;
		r1.last_of_run  = !ctl_s3.e2;
		r1.end_of_frame = 1'b0;
		r2.red          = sat2[0];
		r2.green        = color_mode ? sat2[1] : '0;
		r2.blue         = color_mode ? sat2[2] : '0;
		r2.last_of_run  = 1'b1;
		r2.end_of_frame = ctl_s3.last_row;
	end

	// The earlier beat goes first.
	always_comb begin
		res_cnt = 2'(ctl_s3.valid && ctl_s3.e1) + 2'(ctl_s3.valid && ctl_s3.e2);
		res_a   = ctl_s3.e1 ? r1 : r2;
		res_b   = r2;
	end

endmodule
`default_nettype wire

// ===== rtl/image_conv3x3_stream.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// image_conv3x3_stream: streaming 3x3 convolution of a raster-order image
// Keeps two line buffers and a two-column window, applies the programmable
// kernel to each channel and queues the filtered pixels for the output.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    action, in_red, in_green, in_blue
//  output    out        out_valid / out_stall  out_red, out_green, out_blue,
//                                              last_of_run, end_of_frame
//  config    in         cfg_write              cfg_index, cfg_data
//
// One pixel is accepted each cycle unless in_stall is high; its results pass
// the first stage, product and row-sum registers to the output queue. Row
// zero yields no beats; later, a row's last pixel yields two (one if the row
// is one pixel wide) and its first none. The output queue holds 16 beats;
// in_stall rises when queued plus in-flight beats exceed 14, so a stalled
// output stops input after a short run. Reset clears the positions, the
// window and the queue; line buffer entries hold whatever was last written.
//
module image_conv3x3_stream
	import ic3_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 action,
	input  wire logic [PIX_W-1:0]     in_red,
	input  wire logic [PIX_W-1:0]     in_green,
	input  wire logic [PIX_W-1:0]     in_blue,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [PIX_W-1:0]          out_red,
	output logic [PIX_W-1:0]          out_green,
	output logic [PIX_W-1:0]          out_blue,
	output logic                      last_of_run,
	output logic                      end_of_frame,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [KREG_W-1:0]    cfg_data
);

	// Configuration registers.
	logic [COL_W-1:0]  width_q;
	logic [ROW_W-1:0]  height_q;
	logic              mode_q;
	logic [KREG_W-1:0] ktop_q;
	logic [KREG_W-1:0] kmid_q;
	logic [KREG_W-1:0] kbot_q;
	kern_t             kern;

	// Position and input stage.
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  w_eff;
	logic [ROW_W-1:0]  h_eff;
	logic [COL_W-1:0]  j_a;
	logic              last_col_a;
	logic              last_row_a;
	px_t               p_a;
	ctl_t              ctl_a;
	logic              in_accept;
	logic [1:0]        n_acc;

	// Line buffer and first stage.
	line_t             line_mem [MAX_WIDTH];
	line_t             line_rd_s1;
	line_t             byp_data_s1;
	logic              byp_s1;
	line_t             line_s1;
	ctl_t              ctl_s1;
	logic [ADDR_W-1:0] j_s1;
	px_t               p_s1;
	logic              i_ge1_s1;
	logic              i_ge2_s1;
	logic              j_ge1_s1;
	logic              j_ge2_s1;

	// Window.
	col_t              win_prev1_q;
	col_t              win_prev2_q;
	col_t              prev2_s1;
	col_t              prev1_s1;
	col_t              cur_s1;

	// Datapath results and output queue.
	logic [1:0]        res_cnt;
	res_t              res_a;
	res_t              res_b;
	res_t              fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]  fifo_cnt_q;
	logic [CNT_W-1:0]  reserved_q;
	logic              pop;
	res_t              head;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			mode_q   <= 1'b0;
			ktop_q   <= KTOP_RST;
			kmid_q   <= KMID_RST;
			kbot_q   <= KBOT_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:   width_q  <= cfg_data[COL_W-1:0];
				REG_IMAGE_HEIGHT:  height_q <= cfg_data[ROW_W-1:0];
				REG_COLOR_MODE:    mode_q   <= cfg_data[0];
				REG_KERNEL_TOP:    ktop_q   <= cfg_data;
				REG_KERNEL_MIDDLE: kmid_q   <= cfg_data;
				REG_KERNEL_BOTTOM: kbot_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign kern = {kbot_q, kmid_q, ktop_q};

	// Effective sizes and position of the incoming pixel.
	always_comb begin
		if (width_q == '0) begin
			w_eff = COL_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = COL_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff      = (height_q == '0) ? ROW_W'(1) : height_q;
		j_a        = (32'(col_q) >= MAX_WIDTH) ? COL_W'(MAX_WIDTH - 1) : col_q;
		last_col_a = ((COL_W + 1)'(j_a) + (COL_W + 1)'(1)) >= (COL_W + 1)'(w_eff);
		last_row_a = row_q >= h_eff;
		// Flush items and anything in the flush row count as zero pixels.
		if (action || last_row_a) begin
			p_a = '0;
		end else begin
			p_a = {in_blue, in_green, in_red};
		end
		if (!mode_q) begin
			p_a[1] = '0;
			p_a[2] = '0;
		end
		ctl_a.valid    = 1'b1;
		ctl_a.e1       = (row_q != '0) && (j_a != '0);
		ctl_a.e2       = (row_q != '0) && last_col_a;
		ctl_a.last_row = last_row_a;
		n_acc          = in_accept ? (2'(ctl_a.e1) + 2'(ctl_a.e2)) : 2'd0;
	end

	assign in_stall  = reserved_q > CNT_W'(FIFO_DEPTH - 2);
	assign in_accept = in_valid && !in_stall;

	// Column and row counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (last_col_a) begin
				col_q <= '0;
				row_q <= last_row_a ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= j_a + COL_W'(1);
			end
		end
	end

	// Line buffer: read at the new column, written back in the cycle after.
	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			line_mem[j_s1] <= '{upper: line_s1.middle, middle: p_s1};
		end
		if (in_accept) begin
			line_rd_s1 <= line_mem[j_a[ADDR_W-1:0]];
		end
	end

	// First stage registers; bypass covers a one-pixel-wide image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			byp_s1 <= 1'b0;
		end else begin
			ctl_s1 <= in_accept ? ctl_a : '0;
			byp_s1 <= in_accept && ctl_s1.valid && (j_s1 == j_a[ADDR_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			j_s1        <= j_a[ADDR_W-1:0];
			p_s1        <= p_a;
			i_ge1_s1    <= row_q != '0;
			i_ge2_s1    <= row_q > ROW_W'(1);
			j_ge1_s1    <= j_a != '0;
			j_ge2_s1    <= j_a > COL_W'(1);
			byp_data_s1 <= '{upper: line_s1.middle, middle: p_s1};
		end
	end

	assign line_s1 = byp_s1 ? byp_data_s1 : line_rd_s1;

	// Window columns with the image border read as zero.
	always_comb begin
		cur_s1[0] = i_ge2_s1 ? line_s1.upper : '0;
		cur_s1[1] = i_ge1_s1 ? line_s1.middle : '0;
		cur_s1[2] = p_s1;
		prev1_s1  = j_ge1_s1 ? win_prev1_q : '0;
		prev2_s1  = j_ge2_s1 ? win_prev2_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_prev1_q <= '0;
			win_prev2_q <= '0;
		end else if (ctl_s1.valid) begin
			win_prev1_q <= cur_s1;
			win_prev2_q <= prev1_s1;
		end
	end

	ic3_kernel_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s1     (ctl_s1),
		.prev2_s1   (prev2_s1),
		.prev1_s1   (prev1_s1),
		.cur_s1     (cur_s1),
		.kern       (kern),
		.color_mode (mode_q),
		.res_cnt    (res_cnt),
		.res_a      (res_a),
		.res_b      (res_b)
	);

	// Output queue: up to two beats in, one beat out per cycle while out_stall is low.
	assign pop = (fifo_cnt_q != '0) && !out_stall;

	always_ff @(posedge clk) begin
		if (res_cnt != 2'd0) begin
			fifo_q[wr_ptr_q] <= res_a;
		end
		if (res_cnt == 2'd2) begin
			fifo_q[wr_ptr_q + FIFO_AW'(1)] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			reserved_q <= '0;
		end else begin
			wr_ptr_q   <= wr_ptr_q + FIFO_AW'(res_cnt);
			rd_ptr_q   <= rd_ptr_q + FIFO_AW'(pop);
			fifo_cnt_q <= fifo_cnt_q + CNT_W'(res_cnt) - CNT_W'(pop);
			// Room is booked when a pixel enters and freed when its beat leaves.
			reserved_q <= reserved_q + CNT_W'(n_acc) - CNT_W'(pop);
		end
	end

	assign head         = fifo_q[rd_ptr_q];
	assign out_valid    = fifo_cnt_q != '0;
	assign out_red      = head.red;
	assign out_green    = head.green;
	assign out_blue     = head.blue;
	assign last_of_run  = head.last_of_run;
	assign end_of_frame = head.end_of_frame;

	// Checks.
	a_reserve_bound: assert property (@(posedge clk) disable iff (!arst_n)
		reserved_q <= CNT_W'(FIFO_DEPTH))
		else $error("booked output space exceeds the queue");

	a_queue_booked: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= reserved_q)
		else $error("queue holds beats that were never booked");

	a_results_arrive: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |-> ##3 (res_cnt == $past(n_acc, 3)))
		else $error("datapath result count differs from the pixel's booking");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < MAX_WIDTH)
		else $error("column counter beyond line buffer");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> last_of_run)
		else $error("frame end beat not marked last of run");

endmodule
`default_nettype wire

// ===== sim/image_conv3x3_stream_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_conv3x3_stream_tb: self-checking bench for the 3x3 convolution stream
// Sends raster-order frames with random pixels, kernels, sizes and color modes.
// A scoreboard rebuilds the line history and the sliding window, works out
// every filtered pixel and compares each output beat field by field. Both
// sides idle and stall at random, and one long output hold fills the block.
// ----------------------------------------------------------------------------
module image_conv3x3_stream_tb;
	import ic3_pkg::*;

	localparam int IDLE_LIMIT    = 5000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int TOTAL_ITEMS   = 1400;
	localparam int REPORT_MAX    = 200;

	// Tracks the block's registers, line buffers and window, and holds the
	// filtered pixels that are still due on the output.
	class window_scoreboard;
		logic [COL_W-1:0] width_reg;
		logic [ROW_W-1:0] height_reg;
		logic             rgb_mode;
		kern_t            kernel;
		px_t              upper_row [MAX_WIDTH];
		px_t              middle_row [MAX_WIDTH];
		col_t             back2;
		col_t             back1;
		int unsigned      col_pos;
		int unsigned      row_pos;
		res_t             expected_pixels [$];
		int               errors;
		int               beats_checked;
		int               frames_ended;
		int               saturated;

		function new();
			width_reg  = WIDTH_RST;
			height_reg = HEIGHT_RST;
			rgb_mode   = 1'b0;
			kernel[0]  = KTOP_RST;
			kernel[1]  = KMID_RST;
			kernel[2]  = KBOT_RST;
			foreach (upper_row[n]) begin
				upper_row[n]  = '0;
				middle_row[n] = '0;
			end
			back2   = '0;
			back1   = '0;
			col_pos = 0;
			row_pos = 0;
			errors  = 0;
			beats_checked = 0;
			frames_ended  = 0;
			saturated     = 0;
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		function void set_reg(cfg_reg_t idx, logic [KREG_W-1:0] val);
			case (idx)
				REG_IMAGE_WIDTH:   width_reg  = val[COL_W-1:0];
				REG_IMAGE_HEIGHT:  height_reg = val[ROW_W-1:0];
				REG_COLOR_MODE:    rgb_mode   = val[0];
				REG_KERNEL_TOP:    kernel[0]  = val;
				REG_KERNEL_MIDDLE: kernel[1]  = val;
				REG_KERNEL_BOTTOM: kernel[2]  = val;
				default: ;
			endcase
		endfunction

		// Weighted sum of one channel over a 3x3 window, truncated and clamped.
		function pix_t filter_window(col_t left, col_t centre, col_t right, int ch);
			logic [63:0] acc;
			int r;
			acc = '0;
			for (r = 0; r < NUM_TAPS; r++)
				acc += 64'(left[r][ch]) * 64'(kernel[r][0])
					+ 64'(centre[r][ch]) * 64'(kernel[r][1])
					+ 64'(right[r][ch]) * 64'(kernel[r][2]);
			acc = acc >> COEF_FRAC_BITS;
			if (acc > 64'd255) begin
				saturated++;
				return '1;
			end
			return acc[PIX_W-1:0];
		endfunction

		function res_t filtered_pixel(col_t left, col_t centre, col_t right);
			res_t px;
			px.red          = filter_window(left, centre, right, 0);
			px.green        = rgb_mode ? filter_window(left, centre, right, 1) : '0;
			px.blue         = rgb_mode ? filter_window(left, centre, right, 2) : '0;
			px.last_of_run  = 1'b0;
			px.end_of_frame = 1'b0;
			return px;
		endfunction

		// Advance the window by one accepted input beat and queue its results.
		function void note_pixel(logic flush, pix_t r, pix_t g, pix_t b);
			int unsigned w, h, j, i;
			logic last_col, last_row;
			px_t  p;
			col_t cur, prev1, prev2;
			res_t outs [2];
			int   n, k;
			w = width_reg;
			if (w == 0) w = 1;
			if (w > MAX_WIDTH) w = MAX_WIDTH;
			h = height_reg;
			if (h == 0) h = 1;
			j = col_pos;
			if (j >= MAX_WIDTH) j = MAX_WIDTH - 1;
			i = row_pos;
			last_col = (j + 1 >= w);
			last_row = (i >= h);

			// Flush items and anything in the flush row enter as zero pixels.
			p = {b, g, r};
			if (flush || last_row) p = '0;
			if (!rgb_mode) begin
				p[1] = '0;
				p[2] = '0;
			end

			cur[0] = (i >= 2) ? upper_row[j] : '0;
			cur[1] = (i >= 1) ? middle_row[j] : '0;
			cur[2] = p;
			prev2  = (j >= 2) ? back2 : '0;
			prev1  = (j >= 1) ? back1 : '0;

			n = 0;
			if (i >= 1) begin
				if (j >= 1) begin
					outs[n] = filtered_pixel(prev2, prev1, cur);
					n++;
				end
				if (last_col) begin
					outs[n] = filtered_pixel(prev1, cur, '0);
					n++;
				end
			end
			if (n > 0) begin
				outs[n-1].last_of_run = 1'b1;
				if (last_row && last_col) begin
					outs[n-1].end_of_frame = 1'b1;
					frames_ended++;
				end
			end
			for (k = 0; k < n; k++)
				expected_pixels.push_back(outs[k]);

			upper_row[j]  = middle_row[j];
			middle_row[j] = p;
			back2 = prev1;
			back1 = cur;
			if (last_col) begin
				col_pos = 0;
				row_pos = last_row ? 0 : ((i + 1) & 32'h1FFF);
			end else begin
				col_pos = (j + 1) & 32'h7FF;
			end
		endfunction

		function void compare_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= REPORT_MAX)
					$error("%s: expected %0d, actual %0d", name, want, got);
			end
		endfunction

		function void check_beat(res_t got);
			res_t want;
			if (expected_pixels.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$error("output beat with nothing due: red %0d green %0d blue %0d",
						got.red, got.green, got.blue);
				return;
			end
			want = expected_pixels.pop_front();
			beats_checked++;
			compare_field("out_red", want.red, got.red);
			compare_field("out_green", want.green, got.green);
			compare_field("out_blue", want.blue, got.blue);
			compare_field("last_of_run", PIX_W'(want.last_of_run), PIX_W'(got.last_of_run));
			compare_field("end_of_frame", PIX_W'(want.end_of_frame),
				PIX_W'(got.end_of_frame));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic             action;
	pix_t             in_red;
	pix_t             in_green;
	pix_t             in_blue;
	logic             out_valid;
	logic             out_stall;
	pix_t             out_red;
	pix_t             out_green;
	pix_t             out_blue;
	logic             last_of_run;
	logic             end_of_frame;
	logic             cfg_write;
	cfg_reg_t         cfg_index;
	logic [KREG_W-1:0] cfg_data;

	window_scoreboard sb;
	int               items_sent = 0;
	int               idle_cycles = 0;
	int               in_held_cycles = 0;
	bit               tx_quiet = 1'b0;
	bit               hold_req = 1'b0;
	bit               hold_on = 1'b0;

	image_conv3x3_stream u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.in_red       (in_red),
		.in_green     (in_green),
		.in_blue      (in_blue),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Output monitor: every accepted output beat goes to the scoreboard; held input cycles are counted.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_beat(res_t'({out_red, out_green, out_blue, last_of_run, end_of_frame}));
		if (arst_n && in_valid && in_stall)
			in_held_cycles++;
	end

	// Watchdog: ends the run when no beat moves on any port for too long.
	always @(posedge clk) begin
		if (!arst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$error("no beat moved for %0d cycles", idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		return ($urandom_range(0, 39) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
	endfunction

	function automatic pix_t rand_pix();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return pix_t'($urandom);
		endcase
	endfunction

	function automatic coef_t rand_coef();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2, 3:    return coef_t'($urandom);
			default: return coef_t'($urandom_range(0, 'h1400));
		endcase
	endfunction

	function automatic logic [KREG_W-1:0] rand_krow();
		return {rand_coef(), rand_coef(), rand_coef()};
	endfunction

	// Output side: random stalls, quiet stretches and the requested long hold.
	initial begin : receiver
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				hold_on = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				hold_on  = 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(50, 200)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b1;
				repeat (pick_gap()) @(posedge clk);
			end
		end
	end

	// Register write; the enable drops between writes so they never overlap.
	task automatic write_reg(cfg_reg_t idx, logic [KREG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// Offer one input beat, wait for it to be taken, then maybe idle.
	task automatic send_beat(logic flush, pix_t r, pix_t g, pix_t b);
		int gap;
		in_valid <= 1'b1;
		action   <= flush;
		in_red   <= r;
		in_green <= g;
		in_blue  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_pixel(flush, r, g, b);
		items_sent++;
		gap = (!tx_quiet && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending, let every due pixel come out, then give the pipeline time.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One frame of h image rows and the flush row, with a little noise.
	task automatic send_frame(int w, int h);
		int n;
		for (n = 0; n < w * h; n++)
			send_beat($urandom_range(0, 31) == 0, rand_pix(), rand_pix(), rand_pix());
		for (n = 0; n < w; n++)
			send_beat($urandom_range(0, 15) != 0, rand_pix(), rand_pix(), rand_pix());
	endtask

	task automatic program_frame(int wreg, int hreg);
		write_reg(REG_IMAGE_WIDTH, KREG_W'(wreg));
		write_reg(REG_IMAGE_HEIGHT, KREG_W'(hreg));
		write_reg(REG_COLOR_MODE, KREG_W'($urandom_range(0, 1)));
		if ($urandom_range(0, 1)) write_reg(REG_KERNEL_TOP, rand_krow());
		if ($urandom_range(0, 1)) write_reg(REG_KERNEL_MIDDLE, rand_krow());
		if ($urandom_range(0, 1)) write_reg(REG_KERNEL_BOTTOM, rand_krow());
	endtask

	// Main sequence.
	initial begin : stimulus
		int w, h, frame_idx;
		sb = new();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		action    <= 1'b0;
		in_red    <= '0;
		in_green  <= '0;
		in_blue   <= '0;
		cfg_write <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Grey mode with the reset kernel: a flush inside the image rows and
		// a pixel inside the flush row, channel extremes throughout.
		write_reg(REG_IMAGE_WIDTH, 3);
		write_reg(REG_IMAGE_HEIGHT, 2);
		send_beat(1'b0, 8'd0, 8'd255, 8'd255);
		send_beat(1'b0, 8'd255, 8'd0, 8'd0);
		send_beat(1'b1, 8'd77, 8'd88, 8'd99);
		send_beat(1'b0, 8'd255, 8'd255, 8'd255);
		send_beat(1'b0, 8'd1, 8'd2, 8'd3);
		send_beat(1'b0, 8'd128, 8'd64, 8'd32);
		send_beat(1'b1, 8'd0, 8'd0, 8'd0);
		send_beat(1'b0, 8'd200, 8'd200, 8'd200);
		send_beat(1'b1, 8'd255, 8'd255, 8'd255);
		settle();

		// Zero sizes act as one pixel; full-scale kernel saturates.
		write_reg(REG_COLOR_MODE, 1);
		write_reg(REG_KERNEL_TOP, '1);
		write_reg(REG_KERNEL_MIDDLE, '1);
		write_reg(REG_KERNEL_BOTTOM, '1);
		write_reg(REG_IMAGE_WIDTH, 0);
		write_reg(REG_IMAGE_HEIGHT, 0);
		send_beat(1'b0, 8'd255, 8'd0, 8'd1);
		send_beat(1'b1, 8'd0, 8'd0, 8'd0);
		settle();

		// Tallest frame, then width, height and mode change in the middle of
		// row one so the position lands past the new last column and row.
		write_reg(REG_IMAGE_WIDTH, 4);
		write_reg(REG_IMAGE_HEIGHT, 8191);
		write_reg(REG_KERNEL_TOP, 48'h2000_4000_2000);
		write_reg(REG_KERNEL_MIDDLE, 48'h0000_4000_0000);
		write_reg(REG_KERNEL_BOTTOM, 48'h1000_0000_3000);
		send_beat(1'b0, 8'd255, 8'd255, 8'd255);
		send_beat(1'b0, 8'd0, 8'd0, 8'd0);
		send_beat(1'b0, 8'd255, 8'd0, 8'd128);
		send_beat(1'b0, 8'd17, 8'd34, 8'd51);
		send_beat(1'b0, 8'd200, 8'd100, 8'd50);
		send_beat(1'b1, 8'd9, 8'd9, 8'd9);
		settle();
		write_reg(REG_IMAGE_WIDTH, 2);
		write_reg(REG_IMAGE_HEIGHT, 1);
		write_reg(REG_COLOR_MODE, 0);
		send_beat(1'b0, 8'd255, 8'd255, 8'd255);
		settle();

		// Widest row: a width register above the line length ends the row at
		// the line end; a narrower flush row then closes the frame.
		program_frame(2047, 1);
		repeat (MAX_WIDTH)
			send_beat($urandom_range(0, 31) == 0, rand_pix(), rand_pix(), rand_pix());
		settle();
		write_reg(REG_IMAGE_WIDTH, 2);
		send_beat(1'b1, rand_pix(), rand_pix(), rand_pix());
		send_beat(1'b0, rand_pix(), rand_pix(), rand_pix());
		settle();

		// Random frames, mostly small; the first one runs into the long hold.
		frame_idx = 0;
		while (items_sent < TOTAL_ITEMS) begin
			settle();
			if (frame_idx == 0) begin
				w = 24;
				h = 4;
			end else begin
				w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 48);
				h = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
			end
			program_frame((w == 1 && $urandom_range(0, 1)) ? 0 : w,
				(h == 1 && $urandom_range(0, 1)) ? 0 : h);
			tx_quiet = (frame_idx == 0) || ($urandom_range(0, 4) == 0);
			// Start the frame only once the receiver has begun its hold.
			if (frame_idx == 0) begin
				hold_req = 1'b1;
				wait (hold_on);
			end
			send_frame(w, h);
			frame_idx++;
		end
		settle();

		$display("Covered %0d input beats and %0d output beats over %0d frame ends.",
			items_sent, sb.beats_checked, sb.frames_ended);
		$display("Widths 1 to %0d, grey and rgb, %0d clamped sums, input held %0d cycles.",
			MAX_WIDTH, sb.saturated, in_held_cycles);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
